FILE: hw/rtl/sequence_reorder_jitter_buffer_assert.svh
// ----------------------------------------------------------------------------
// sequence_reorder_jitter_buffer_assert.svh
// assertion macros for the jitter buffer, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_JITTER_BUFFER_ASSERT_SVH
`define SEQUENCE_REORDER_JITTER_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define SRJB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("srjb assertion failed");

// antecedent in one cycle implies consequent in the next
`define SRJB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srjb next-cycle assertion failed");

`else

`define SRJB_ASSERT(label, clk, rst_n, prop)

`define SRJB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/srjb_pkg.sv
// ----------------------------------------------------------------------------
// srjb_pkg
// shared constants and types of the sequence reorder jitter buffer
// ----------------------------------------------------------------------------
package srjb_pkg;

    // sizes; SLOTS must be a power of two (slot index is the low seq bits)
    localparam int CAPACITY = 8;
    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int DIFF_W   = SEQ_W + 1;

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_OCCUPIED  = 3'd1,
        ST_RESYNC    = 3'd2,
        ST_NONE      = 3'd3,
        ST_DELIVERED = 3'd4,
        ST_LOST      = 3'd5
    } srjb_status_t;

    // slot memory control from the controller
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } srjb_ram_req_t;

endpackage

FILE: hw/rtl/sequence_reorder_jitter_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_jitter_buffer
// reorder buffer for packet handles keyed by 16-bit sequence numbers. each
// request is a write (file a handle under its sequence number) or a read
// (take the next handle in order) and gives exactly one result with a status
// and a handle. a request is captured in an input register, decided
// combinationally against the slot valid flags and the window pointers, and
// lands in a result register, so one request can be taken every clock while
// the result side does not stall. the request passes through the input
// register and then the result register before its result is offered, and
// the handle memory read on a delivery lands in the result stage together
// with the status. the request side only stalls while a request waits in the
// input register and the result register is full and stalled. the valid flags
// are flip-flops cleared at once by reset or by a resync, so there is no
// clearing pass and the block takes requests right out of reset.
// ----------------------------------------------------------------------------
`include "sequence_reorder_jitter_buffer_assert.svh"

module sequence_reorder_jitter_buffer (
    input  logic                          clk,
    input  logic                          rst_n,

    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [srjb_pkg::SEQ_W-1:0]    seq,
    input  logic [srjb_pkg::HANDLE_W-1:0] handle,

    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [srjb_pkg::HANDLE_W-1:0] handle_out
);

    // input register
    logic                          req_valid_reg;
    logic                          req_valid_next;
    logic                          func_reg;
    logic [srjb_pkg::SEQ_W-1:0]    seq_reg;
    logic [srjb_pkg::HANDLE_W-1:0] handle_reg;

    // result register (handle data sits in the slot memory read register)
    logic                          res_valid_reg;
    logic                          res_valid_next;
    srjb_pkg::srjb_status_t        status_reg;

    logic                          in_take;
    logic                          res_free;
    logic                          advance;
    srjb_pkg::srjb_status_t        dec_status;
    srjb_pkg::srjb_ram_req_t       ram_req;
    logic [srjb_pkg::HANDLE_W-1:0] rd_data;

    // the request register moves on when the result register is empty or drained
    assign res_free = !res_valid_reg || !out_stall;
    assign advance  = req_valid_reg && res_free;
    assign in_stall = req_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg && out_stall;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg   <= func;
            seq_reg    <= seq;
            handle_reg <= handle;
        end
        if (advance)
        begin
            status_reg <= dec_status;
        end
    end

    // window pointers and valid flags; state moves only when a request advances
    srjb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .func    (func_reg),
        .seq     (seq_reg),
        .status  (dec_status),
        .ram_req (ram_req)
    );

    // handle storage; the read lands together with the status
    srjb_slot_ram u_slot_ram (
        .clk     (clk),
        .req     (ram_req),
        .wr_data (handle_reg),
        .rd_data (rd_data)
    );

    assign out_valid  = res_valid_reg;
    assign status     = status_reg;
    // handle only goes out on a delivery
    assign handle_out = (status_reg == srjb_pkg::ST_DELIVERED) ? rd_data : '0;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a nonzero handle only accompanies a delivery
    `SRJB_ASSERT(a_handle_only_on_delivery, clk, rst_n,
        !(res_valid_reg && (handle_out != '0)) || (status_reg == srjb_pkg::ST_DELIVERED))

    // stall is only raised while a request is held in the input register
    `SRJB_ASSERT(a_stall_needs_request, clk, rst_n, !in_stall || req_valid_reg)

    // an advancing request always produces a result in the next cycle
    `SRJB_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, res_valid_reg)

    // memory reads happen only for reads that deliver
    `SRJB_ASSERT_NEXT(a_read_is_delivery, clk, rst_n, ram_req.rd_en,
        status_reg == srjb_pkg::ST_DELIVERED)

endmodule

FILE: hw/rtl/srjb_slot_ram.sv
// ----------------------------------------------------------------------------
// srjb_slot_ram
// handle storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srjb_slot_ram (
    input  logic                            clk,
    input  srjb_pkg::srjb_ram_req_t         req,
    input  logic [srjb_pkg::HANDLE_W-1:0]   wr_data,
    output logic [srjb_pkg::HANDLE_W-1:0]   rd_data
);

    logic [srjb_pkg::HANDLE_W-1:0] mem [srjb_pkg::SLOTS];
    logic [srjb_pkg::HANDLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/srjb_ctrl.sv
// ----------------------------------------------------------------------------
// srjb_ctrl
// window pointers, slot valid flags and the per-request decision
// ----------------------------------------------------------------------------
module srjb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          func,
    input  logic [srjb_pkg::SEQ_W-1:0]    seq,
    output srjb_pkg::srjb_status_t        status,
    output srjb_pkg::srjb_ram_req_t       ram_req
);

    logic [srjb_pkg::SLOTS-1:0]  valid_reg;
    logic [srjb_pkg::SLOTS-1:0]  valid_next;
    logic [srjb_pkg::SEQ_W-1:0]  oldest_reg;
    logic [srjb_pkg::SEQ_W-1:0]  oldest_next;
    logic [srjb_pkg::SEQ_W-1:0]  next_reg;
    logic [srjb_pkg::SEQ_W-1:0]  next_next;

    logic [srjb_pkg::DIFF_W-1:0] wr_diff;
    logic [srjb_pkg::DIFF_W-1:0] span;
    logic [srjb_pkg::SLOT_W-1:0] wr_idx;
    logic [srjb_pkg::SLOT_W-1:0] rd_idx;
    logic                        out_of_window;
    logic                        span_lost;
    logic                        wr_en;
    logic                        rd_en;

    // unwrapped differences, sign in the top bit
    assign wr_diff = {1'b0, seq} - {1'b0, oldest_reg};
    assign span    = {1'b0, next_reg} - {1'b0, oldest_reg};
    assign wr_idx  = seq[srjb_pkg::SLOT_W-1:0];
    assign rd_idx  = oldest_reg[srjb_pkg::SLOT_W-1:0];

    assign out_of_window = wr_diff[srjb_pkg::SEQ_W]
        || (wr_diff[srjb_pkg::SEQ_W-1:0] > srjb_pkg::SEQ_W'(srjb_pkg::SLOTS));
    assign span_lost = span[srjb_pkg::SEQ_W]
        || (span[srjb_pkg::SEQ_W-1:0] > srjb_pkg::SEQ_W'(srjb_pkg::CAPACITY));

    always_comb
    begin
        valid_next  = valid_reg;
        oldest_next = oldest_reg;
        next_next   = next_reg;
        status      = srjb_pkg::ST_NONE;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (func)
            srjb_pkg::FUNC_WRITE:
            begin
                if (out_of_window)
                begin
                    // resync: flash clear, restart window around seq
                    valid_next         = '0;
                    valid_next[wr_idx] = 1'b1;
                    oldest_next = seq - srjb_pkg::SEQ_W'(srjb_pkg::CAPACITY);
                    next_next   = seq + srjb_pkg::SEQ_W'(1);
                    status      = srjb_pkg::ST_RESYNC;
                    wr_en       = 1'b1;
                end
                else if (valid_reg[wr_idx])
                begin
                    status = srjb_pkg::ST_OCCUPIED;
                end
                else
                begin
                    valid_next[wr_idx] = 1'b1;
                    status             = srjb_pkg::ST_STORED;
                    wr_en              = 1'b1;
                    if ($signed(wr_diff) >= $signed(span))
                    begin
                        next_next = seq + srjb_pkg::SEQ_W'(1);
                    end
                end
            end
            srjb_pkg::FUNC_READ:
            begin
                if (next_reg == oldest_reg)
                begin
                    status = srjb_pkg::ST_NONE;
                end
                else if (valid_reg[rd_idx])
                begin
                    valid_next[rd_idx] = 1'b0;
                    oldest_next        = oldest_reg + srjb_pkg::SEQ_W'(1);
                    status             = srjb_pkg::ST_DELIVERED;
                    rd_en              = 1'b1;
                end
                else if (span_lost)
                begin
                    oldest_next = oldest_reg + srjb_pkg::SEQ_W'(1);
                    status      = srjb_pkg::ST_LOST;
                end
                else
                begin
                    status = srjb_pkg::ST_NONE;
                end
            end
            default:
            begin
                status = srjb_pkg::ST_NONE;
            end
        endcase
    end

    assign ram_req.wr_en   = en && wr_en;
    assign ram_req.wr_addr = wr_idx;
    assign ram_req.rd_en   = en && rd_en;
    assign ram_req.rd_addr = rd_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            oldest_reg <= '0;
            next_reg   <= '0;
        end
        else if (en)
        begin
            valid_reg  <= valid_next;
            oldest_reg <= oldest_next;
            next_reg   <= next_next;
        end
    end

endmodule

FILE: test/sequence_reorder_jitter_buffer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_reorder_jitter_buffer_checker
// watches the request and result channels of the jitter buffer, keeps its own
// copy of the slot store and the window pointers, predicts the status and
// handle of every accepted request and compares them in order with the results
// ----------------------------------------------------------------------------
module sequence_reorder_jitter_buffer_checker
    import srjb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                func,
    input  logic [SEQ_W-1:0]    seq,
    input  logic [HANDLE_W-1:0] handle,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [2:0]          status,
    input  logic [HANDLE_W-1:0] handle_out,
    output int                  fail_count,
    output int                  outstanding,
    output int                  n_requests,
    output int                  n_delivered,
    output int                  n_lost,
    output int                  n_resync,
    output int                  n_rejected
);

    typedef struct packed {
        srjb_status_t        status;
        logic [HANDLE_W-1:0] handle;
    } playout_t;

    // model of the buffer
    logic [HANDLE_W-1:0] pkt_handle [SLOTS];
    logic                pkt_present [SLOTS];
    logic [SEQ_W-1:0]    oldest;
    logic [SEQ_W-1:0]    next_due;

    playout_t            due_q [$];
    playout_t            want;
    playout_t            got;

    // one request against the model, returns the result it gives
    function automatic playout_t reorder_step(input logic f, input logic [SEQ_W-1:0] s,
                                              input logic [HANDLE_W-1:0] h);
        playout_t         res;
        int               diff;
        int               span;
        logic [SLOT_W-1:0] idx;
        res.handle = '0;
        if (f == FUNC_WRITE)
        begin
            diff = int'(s) - int'(oldest);
            idx  = s[SLOT_W-1:0];
            if (diff < 0 || diff > SLOTS)
            begin
                for (int k = 0; k < SLOTS; k++)
                    pkt_present[k] = 1'b0;
                oldest           = s - SEQ_W'(CAPACITY);
                next_due         = s + 1'b1;
                pkt_handle[idx]  = h;
                pkt_present[idx] = 1'b1;
                res.status       = ST_RESYNC;
            end
            else if (pkt_present[idx])
                res.status = ST_OCCUPIED;
            else
            begin
                pkt_handle[idx]  = h;
                pkt_present[idx] = 1'b1;
                if (diff >= int'(next_due) - int'(oldest))
                    next_due = s + 1'b1;
                res.status = ST_STORED;
            end
        end
        else
        begin
            idx  = oldest[SLOT_W-1:0];
            span = int'(next_due) - int'(oldest);
            if (next_due == oldest)
                res.status = ST_NONE;
            else if (pkt_present[idx])
            begin
                res.handle       = pkt_handle[idx];
                pkt_present[idx] = 1'b0;
                oldest           = oldest + 1'b1;
                res.status       = ST_DELIVERED;
            end
            else if (span < 0 || span > CAPACITY)
            begin
                oldest     = oldest + 1'b1;
                res.status = ST_LOST;
            end
            else
                res.status = ST_NONE;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                pkt_handle[k]  = '0;
                pkt_present[k] = 1'b0;
            end
            oldest      = '0;
            next_due    = '0;
            due_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
            n_requests  <= 0;
            n_delivered <= 0;
            n_lost      <= 0;
            n_resync    <= 0;
            n_rejected  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_q.size() == 0)
                begin
                    $error("result with no request waiting: status %0d handle_out %h",
                           status, handle_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (status !== want.status || handle_out !== want.handle)
                        fail_count <= fail_count + 1;
                    if (status !== want.status)
                        $error("status: expected %0d actual %0d", want.status, status);
                    if (handle_out !== want.handle)
                        $error("handle_out: expected %h actual %h", want.handle, handle_out);
                end
            end
            if (in_valid && !in_stall)
            begin
                got = reorder_step(func, seq, handle);
                due_q.push_back(got);
                n_requests <= n_requests + 1;
                case (got.status)
                    ST_DELIVERED: n_delivered <= n_delivered + 1;
                    ST_LOST:      n_lost      <= n_lost + 1;
                    ST_RESYNC:    n_resync    <= n_resync + 1;
                    ST_OCCUPIED:  n_rejected  <= n_rejected + 1;
                    default:      ;
                endcase
            end
            outstanding <= due_q.size();
        end
    end

endmodule

FILE: test/sequence_reorder_jitter_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_reorder_jitter_buffer_tb
// drives write and read requests into the jitter buffer: a directed opening
// that walks the window edge, occupied slots, resyncs, counter wrap, lost and
// not-yet-lost gaps, then a long random packet stream with reordering, drops,
// duplicates and jumps; both channels idle at random and the checker beside
// the block compares every result
// ----------------------------------------------------------------------------
module sequence_reorder_jitter_buffer_tb;
    import srjb_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                func       = FUNC_WRITE;
    logic [SEQ_W-1:0]    seq        = '0;
    logic [HANDLE_W-1:0] handle     = '0;
    logic                out_stall  = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [2:0]          status;
    logic [HANDLE_W-1:0] handle_out;

    // no idling on either side while set
    logic                quiet      = 1'b0;

    int                  fail_count;
    int                  outstanding;
    int                  n_requests;
    int                  n_delivered;
    int                  n_lost;
    int                  n_resync;
    int                  n_rejected;

    sequence_reorder_jitter_buffer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .seq        (seq),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_out (handle_out)
    );

    sequence_reorder_jitter_buffer_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .seq         (seq),
        .handle      (handle),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .handle_out  (handle_out),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .n_requests  (n_requests),
        .n_delivered (n_delivered),
        .n_lost      (n_lost),
        .n_resync    (n_resync),
        .n_rejected  (n_rejected)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // result side backpressure, about one cycle in five
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 19);
    end

    // present one request and hold it until the block takes it
    task automatic send_request(input logic f, input logic [SEQ_W-1:0] s,
                                input logic [HANDLE_W-1:0] h);
        logic taken;
        while (!quiet && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        seq      <= s;
        handle   <= h;
        // stall is settled by mid cycle, so sample it there
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // hold the request side until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int               pick;
        logic [SEQ_W-1:0] cursor;
        logic [SEQ_W-1:0] last_seq;
        logic [SEQ_W-1:0] s;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---------------- directed opening ----------------
        // empty buffer right out of reset
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        // store at the bottom, then hit the same slot again
        send_request(FUNC_WRITE, 16'h0000, 16'h0000);
        send_request(FUNC_WRITE, 16'h0000, 16'h1234);
        // in-order delivery, read fields ignored
        send_request(FUNC_READ, 16'hffff, 16'hffff);
        send_request(FUNC_READ, 16'h5a5a, 16'ha5a5);
        // window edge: bottom + SLOTS lands on the bottom slot
        send_request(FUNC_WRITE, 16'(SLOTS + 1), 16'hffff);
        send_request(FUNC_WRITE, 16'h0001, 16'h5555);
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        // one past the window forces a resync
        send_request(FUNC_WRITE, 16'(SLOTS + 3), 16'h0f0f);
        // gap lost, then gap not yet lost
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        // late packet below the top does not move the top
        send_request(FUNC_WRITE, 16'(SLOTS - 4), 16'haaaa);
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        // top of the counter range, top pointer wraps to zero
        send_request(FUNC_WRITE, 16'hffff, 16'h8001);
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        // wrapped sequence sits below the bottom and resyncs
        send_request(FUNC_WRITE, 16'h0002, 16'h7ffe);
        send_request(FUNC_READ, 16'h0000, 16'h0000);
        send_request(FUNC_WRITE, 16'h0003, 16'h0001);
        send_request(FUNC_READ, 16'hffff, 16'h0000);
        send_request(FUNC_READ, 16'h0000, 16'hffff);
        // below the bottom without wrap
        send_request(FUNC_WRITE, 16'h1000, 16'h3c3c);
        send_request(FUNC_WRITE, 16'h0ff0, 16'hc3c3);
        send_request(FUNC_READ, 16'h0000, 16'h0000);

        // ---------------- random packet stream ----------------
        cursor   = 16'($urandom_range(0, 65535));
        last_seq = cursor;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            quiet <= (i >= 700 && i < 1000);
            if (i == 1200)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                // next packet of the stream, slightly out of order
                s        = cursor + 16'($urandom_range(0, 12)) - 16'd3;
                cursor   = cursor + 1'b1;
                last_seq = s;
                send_request(FUNC_WRITE, s, 16'($urandom_range(0, 65535)));
            end
            else if (pick < 47)
                // duplicate of the last packet
                send_request(FUNC_WRITE, last_seq, 16'($urandom_range(0, 65535)));
            else if (pick < 90)
                send_request(FUNC_READ, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
            else if (pick < 95)
                // stray packet anywhere in the sequence space
                send_request(FUNC_WRITE, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
            else
            begin
                // stream restarts, often just below the counter wrap
                if ($urandom_range(0, 1) == 0)
                    cursor = 16'($urandom_range(65400, 65535));
                else
                    cursor = 16'($urandom_range(0, 65535));
                last_seq = cursor;
                send_request(FUNC_WRITE, cursor, 16'($urandom_range(0, 65535)));
                cursor = cursor + 1'b1;
            end
        end

        quiet <= 1'b0;
        drain_results();
        repeat (8) @(posedge clk);

        $display("requests %0d: delivered %0d, lost %0d, resyncs %0d, rejected %0d",
                 n_requests, n_delivered, n_lost, n_resync, n_rejected);
        $display("stream covered reorder, duplicates, window edge, wrap and random stalls");
        if (fail_count == 0)
            $display("sequence_reorder_jitter_buffer_tb OK");
        else
            $display("sequence_reorder_jitter_buffer_tb NOT OK");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("sequence_reorder_jitter_buffer_tb NOT OK");
        $finish;
    end

endmodule
